// ----- hw/rtl/bsde_pkg.sv -----
package bsde_pkg;

    localparam int T_W      = 22;   // param_t, unsigned Q6.16
    localparam int COORD_W  = 32;   // signed Q16.16
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = FRAC_W + 1;   // weight in [0, 1.0]
    localparam int SPAN_W   = 3;    // knot span never exceeds the largest degree (7)

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // register index taken from paddr[2]
    localparam logic [0:0] REG_POINT_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_WEIGHT,
        ST_DIV,
        ST_MUL,
        ST_SHIFT,
        ST_ROT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [T_W-1:0]    num;
        logic [SPAN_W-1:0] span;
    } wdiv_req_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] weight;
    } wdiv_resp_t;

endpackage

// ----- hw/rtl/bsde_store.sv -----
module bsde_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [95:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [95:0]   rdata
);

    logic [95:0] mem [DEPTH];
    logic [95:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/bsde_wdiv.sv -----
// Weight divider: num / span, saturated to 1.0, two quotient bits per cycle.
module bsde_wdiv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bsde_pkg::wdiv_req_t    req,
    output bsde_pkg::wdiv_resp_t   resp
);

    localparam int SW = bsde_pkg::SPAN_W;
    localparam int FW = bsde_pkg::FRAC_W;
    localparam int WW = bsde_pkg::WEIGHT_W;
    localparam int TW = bsde_pkg::T_W;

    logic          run_reg,  run_next;
    logic          done_reg, done_next;
    logic [2:0]    cnt_reg,  cnt_next;
    logic [SW-1:0] rem_reg,  rem_next;
    logic [SW-1:0] span_reg, span_next;
    logic [FW-1:0] low_reg,  low_next;
    logic [FW-1:0] q_reg,    q_next;
    logic [WW-1:0] w_reg,    w_next;

    logic [SW+1:0] r4;
    logic [SW+1:0] m1, m2, m3, sub;
    logic [SW+1:0] diff;
    logic [1:0]    digit;
    logic          sat;

    always_comb
    begin
        r4 = {rem_reg, low_reg[FW-1:FW-2]};
        m1 = (SW+2)'(span_reg);
        m2 = m1 << 1;
        m3 = m1 + m2;
        if (r4 >= m3)
        begin
            digit = 2'd3;
            sub   = m3;
        end
        else if (r4 >= m2)
        begin
            digit = 2'd2;
            sub   = m2;
        end
        else if (r4 >= m1)
        begin
            digit = 2'd1;
            sub   = m1;
        end
        else
        begin
            digit = 2'd0;
            sub   = '0;
        end
        diff = r4 - sub;
        // quotient >= 1.0 whenever num reaches span << 16
        sat  = req.num >= TW'({req.span, {FW{1'b0}}});
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        span_next = span_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        w_next    = w_reg;
        if (req.start)
        begin
            span_next = req.span;
            if (sat)
            begin
                w_next    = WW'(1) << FW;
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else
            begin
                // integer part is already below span
                rem_next = req.num[FW+SW-1:FW];
                low_next = req.num[FW-1:0];
                q_next   = '0;
                cnt_next = '0;
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            rem_next = diff[SW-1:0];
            low_next = low_reg << 2;
            q_next   = {q_reg[FW-3:0], digit};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                w_next    = {1'b0, q_reg[FW-3:0], digit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        span_reg <= span_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        w_reg    <= w_next;
    end

    assign resp.done   = done_reg;
    assign resp.weight = w_reg;

endmodule

// ----- hw/rtl/bsde_blend.sv -----
// a*(1-w) + b*w computed as (a << 16) + (b - a)*w, rounded half up.
// One coordinate per cycle; the result appears in the cycle after its operands.
module bsde_blend (
    input  logic                                clk,
    input  logic signed [bsde_pkg::COORD_W-1:0] a,
    input  logic signed [bsde_pkg::COORD_W-1:0] b,
    input  logic [bsde_pkg::WEIGHT_W-1:0]       weight,
    output logic signed [bsde_pkg::COORD_W-1:0] result
);

    localparam int CW = bsde_pkg::COORD_W;
    localparam int WW = bsde_pkg::WEIGHT_W;
    localparam int FW = bsde_pkg::FRAC_W;
    localparam int PW = CW + 1 + WW + 1;

    logic signed [CW:0]   diff;
    logic signed [PW-1:0] prod_next, prod_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [PW-1:0] acc;

    always_comb
    begin
        diff      = (CW+1)'(b) - (CW+1)'(a);
        prod_next = PW'(diff) * PW'($signed({1'b0, weight}));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a;
    end

    always_comb
    begin
        acc    = (PW'(a_reg) <<< FW) + prod_reg + PW'(1 << (FW - 1));
        result = acc[FW+CW-1:FW];
    end

endmodule

// ----- hw/rtl/bspline_de_boor_eval.sv -----
// Channel     Direction  Signals                                        Handshake
// item in     in         operation point_index point_x/y/z param_t      start & !busy
// result out  out        curve_x curve_y curve_z span_index             result_valid (1 cycle)
// config      in/out     psel penable pwrite paddr pwdata prdata pready APB, pready tied high
//
// A write item goes straight to the point store; busy stays low. An evaluate item keeps
// busy high until the state machine is idle again, through the radix-4 weight divider
// (8 steps per blend) and the one shared multiplier that blends x, y and z in turn;
// a saturated weight skips the divider steps.
// Reset is asynchronous, active low; point_count comes up as 4, the point store is
// not cleared. result_valid is a single-cycle strobe; the receiver cannot stall.
module bspline_de_boor_eval #(
    parameter int DEGREE     = 3,
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [21:0]        param_t,
    output logic               result_valid,
    output logic signed [31:0] curve_x,
    output logic signed [31:0] curve_y,
    output logic signed [31:0] curve_z,
    output logic [5:0]         span_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int NW   = (CW > 7) ? CW : 7;
    localparam int IXW  = (CW > 6) ? CW : 6;
    localparam int TW   = (CW + 16 > 22) ? CW + 16 : 22;
    localparam int KW   = AW + 2;
    localparam int NUMW = KW + 17;
    localparam int LW   = $clog2(DEGREE + 1);
    localparam int LDW  = $clog2(DEGREE + 2);
    localparam int FW   = bsde_pkg::FRAC_W;
    localparam int SW   = bsde_pkg::SPAN_W;

    bsde_pkg::state_t state_reg, state_next;

    logic [6:0]     point_count_reg, point_count_next;
    logic [LDW-1:0] ld_cnt_reg, ld_cnt_next;
    logic [LW-1:0]  k_reg, k_next;
    logic [LW-1:0]  i_reg, i_next;
    logic [1:0]     mc_reg, mc_next;

    logic [21:0]    t_reg, t_next;
    logic [21:0]    tc_reg, tc_next;
    logic [AW-1:0]  mu_reg, mu_next;
    logic [95:0]    p_reg [DEGREE+1];
    logic [95:0]    p_next [DEGREE+1];
    logic [31:0]    res_reg [3];
    logic [31:0]    res_next [3];

    logic           accept;
    logic           cfg_write;
    logic           mem_we;
    logic [AW-1:0]  raddr;
    logic [95:0]    rdata;

    logic [NW-1:0]  pc_ext;
    logic [CW-1:0]  n_used;
    logic [TW-1:0]  tmax;
    logic [21:0]    tc;
    logic [NW:0]    mu_raw, nm1, mu_sel;

    logic signed [KW-1:0]   jx, nd, lo, hi, span_d;
    logic signed [NUMW-1:0] num_d;

    bsde_pkg::wdiv_req_t  div_req;
    bsde_pkg::wdiv_resp_t div_resp;

    logic signed [31:0] bl_a, bl_b, bl_res;

    function automatic logic signed [KW-1:0] knot_at(
        input logic signed [KW-1:0] x,
        input logic signed [KW-1:0] lim
    );
        logic signed [KW-1:0] v;
        v = x;
        if (v < 0)
        begin
            v = '0;
        end
        if (v > lim)
        begin
            v = lim;
        end
        return v;
    endfunction

    assign accept    = start && (state_reg == bsde_pkg::ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign mem_we    = accept && (operation == bsde_pkg::OP_WRITE)
                       && (IXW'(point_index) < IXW'(MAX_POINTS));

    bsde_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(point_index)),
        .wdata ({point_z, point_y, point_x}),
        .raddr (raddr),
        .rdata (rdata)
    );

    bsde_wdiv u_wdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    bsde_blend u_blend (
        .clk    (clk),
        .a      (bl_a),
        .b      (bl_b),
        .weight (div_resp.weight),
        .result (bl_res)
    );

    // curve geometry: points in use, clamped t and span index
    always_comb
    begin
        pc_ext = NW'(point_count_reg);
        if (pc_ext < NW'(DEGREE + 1))
        begin
            n_used = CW'(DEGREE + 1);
        end
        else if (pc_ext > NW'(MAX_POINTS))
        begin
            n_used = CW'(MAX_POINTS);
        end
        else
        begin
            n_used = CW'(pc_ext);
        end
        tmax   = TW'(n_used - CW'(DEGREE)) << FW;
        tc     = (TW'(t_reg) > tmax) ? tmax[21:0] : t_reg;
        mu_raw = (NW+1)'(tc[21:16]) + (NW+1)'(DEGREE);
        nm1    = (NW+1)'(n_used) - (NW+1)'(1);
        mu_sel = (mu_raw > nm1) ? nm1 : mu_raw;
    end

    // knots and weight numerator for blend i of level k
    always_comb
    begin
        jx     = $signed(KW'(mu_reg)) - $signed(KW'(k_reg)) + $signed(KW'(i_reg))
                 + $signed(KW'(1)) - $signed(KW'(DEGREE));
        nd     = $signed(KW'(n_used)) - $signed(KW'(DEGREE));
        lo     = knot_at(jx, nd);
        hi     = knot_at(jx + $signed(KW'(k_reg)), nd);
        span_d = hi - lo;
        num_d  = $signed(NUMW'(tc_reg)) - (NUMW'(lo) <<< FW);

        div_req.start = (state_reg == bsde_pkg::ST_WEIGHT);
        div_req.num   = (num_d < 0) ? '0 : num_d[21:0];
        div_req.span  = (span_d < 1) ? SW'(1) : span_d[SW-1:0];
    end

    always_comb
    begin
        raddr = (mu_reg - AW'(DEGREE)) + AW'(ld_cnt_reg);
        case (mc_reg)
            2'd0:
            begin
                bl_a = $signed(p_reg[0][31:0]);
                bl_b = $signed(p_reg[1][31:0]);
            end
            2'd1:
            begin
                bl_a = $signed(p_reg[0][63:32]);
                bl_b = $signed(p_reg[1][63:32]);
            end
            2'd2:
            begin
                bl_a = $signed(p_reg[0][95:64]);
                bl_b = $signed(p_reg[1][95:64]);
            end
            default:
            begin
                bl_a = '0;
                bl_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsde_pkg::ST_IDLE:
            begin
                if (start && operation == bsde_pkg::OP_EVAL)
                begin
                    state_next = bsde_pkg::ST_SETUP;
                end
            end
            bsde_pkg::ST_SETUP:
            begin
                state_next = bsde_pkg::ST_LOAD;
            end
            bsde_pkg::ST_LOAD:
            begin
                if (ld_cnt_reg == LDW'(DEGREE + 1))
                begin
                    state_next = bsde_pkg::ST_WEIGHT;
                end
            end
            bsde_pkg::ST_WEIGHT:
            begin
                state_next = bsde_pkg::ST_DIV;
            end
            bsde_pkg::ST_DIV:
            begin
                if (div_resp.done)
                begin
                    state_next = bsde_pkg::ST_MUL;
                end
            end
            bsde_pkg::ST_MUL:
            begin
                if (mc_reg == 2'd3)
                begin
                    state_next = (k_reg == LW'(1)) ? bsde_pkg::ST_OUT : bsde_pkg::ST_SHIFT;
                end
            end
            bsde_pkg::ST_SHIFT:
            begin
                if ((LW+1)'(i_reg) + (LW+1)'(1) < (LW+1)'(k_reg))
                begin
                    state_next = bsde_pkg::ST_WEIGHT;
                end
                else
                begin
                    state_next = bsde_pkg::ST_ROT;
                end
            end
            bsde_pkg::ST_ROT:
            begin
                if (i_reg == LW'(DEGREE))
                begin
                    state_next = bsde_pkg::ST_WEIGHT;
                end
            end
            bsde_pkg::ST_OUT:
            begin
                state_next = bsde_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bsde_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and counters
    always_comb
    begin
        point_count_next = point_count_reg;
        ld_cnt_next      = ld_cnt_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        mc_next          = mc_reg;
        t_next           = t_reg;
        tc_next          = tc_reg;
        mu_next          = mu_reg;
        p_next           = p_reg;
        res_next         = res_reg;

        if (cfg_write && paddr[2:2] == bsde_pkg::REG_POINT_COUNT)
        begin
            point_count_next = pwdata[6:0];
        end

        case (state_reg)
            bsde_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    t_next = param_t;
                end
            end
            bsde_pkg::ST_SETUP:
            begin
                tc_next     = tc;
                mu_next     = AW'(mu_sel);
                ld_cnt_next = '0;
                k_next      = LW'(DEGREE);
                i_next      = '0;
            end
            bsde_pkg::ST_LOAD:
            begin
                ld_cnt_next = ld_cnt_reg + LDW'(1);
                // the store's read data is registered and arrives in the cycle after its address
                if (ld_cnt_reg != '0)
                begin
                    for (int j = 0; j < DEGREE; j++)
                    begin
                        p_next[j] = p_reg[j+1];
                    end
                    p_next[DEGREE] = rdata;
                end
            end
            bsde_pkg::ST_WEIGHT:
            begin
                mc_next = '0;
            end
            bsde_pkg::ST_MUL:
            begin
                mc_next = mc_reg + 2'd1;
                case (mc_reg)
                    2'd1:    res_next[0] = bl_res;
                    2'd2:    res_next[1] = bl_res;
                    2'd3:    res_next[2] = bl_res;
                    default: ;
                endcase
            end
            bsde_pkg::ST_SHIFT:
            begin
                // new point goes to the tail; the queue moves up one place and the head drops out
                for (int j = 0; j < DEGREE; j++)
                begin
                    p_next[j] = p_reg[j+1];
                end
                p_next[DEGREE] = {res_reg[2], res_reg[1], res_reg[0]};
                i_next = i_reg + LW'(1);
            end
            bsde_pkg::ST_ROT:
            begin
                for (int j = 0; j < DEGREE; j++)
                begin
                    p_next[j] = p_reg[j+1];
                end
                p_next[DEGREE] = p_reg[0];
                if (i_reg == LW'(DEGREE))
                begin
                    i_next = '0;
                    k_next = k_reg - LW'(1);
                end
                else
                begin
                    i_next = i_reg + LW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bsde_pkg::ST_IDLE;
            point_count_reg <= 7'd4;
            ld_cnt_reg      <= '0;
            k_reg           <= '0;
            i_reg           <= '0;
            mc_reg          <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            ld_cnt_reg      <= ld_cnt_next;
            k_reg           <= k_next;
            i_reg           <= i_next;
            mc_reg          <= mc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        tc_reg  <= tc_next;
        mu_reg  <= mu_next;
        p_reg   <= p_next;
        res_reg <= res_next;
    end

    assign busy         = (state_reg != bsde_pkg::ST_IDLE);
    assign result_valid = (state_reg == bsde_pkg::ST_OUT);
    assign curve_x      = $signed(res_reg[0]);
    assign curve_y      = $signed(res_reg[1]);
    assign curve_z      = $signed(res_reg[2]);
    assign span_index   = 6'(mu_reg);
    assign pready       = 1'b1;
    assign prdata       = (paddr[2:2] == bsde_pkg::REG_POINT_COUNT) ?
                          32'(point_count_reg) : 32'd0;

endmodule
